// ----- rtl/expression_syntax_checker_unit_macros.svh -----
// Assertion helpers for the expression syntax checker.
// Both forms sample on the rising edge of clk and are off while rst_n is low.
`ifndef EXPRESSION_SYNTAX_CHECKER_UNIT_MACROS_SVH
`define EXPRESSION_SYNTAX_CHECKER_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ESC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ESC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/esc_pkg.sv -----
`timescale 1ns / 1ps

package esc_pkg;

  // Fixed field widths.
  localparam int CH_W  = 8;
  localparam int POS_W = 12;

  typedef logic [CH_W-1:0]  char_t;
  typedef logic [POS_W-1:0] pos_t;

  // Bracket kind held in each stack cell.
  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_PAREN  = 2'd1,
    KIND_BRACE  = 2'd2,
    KIND_SQUARE = 2'd3
  } kind_t;

  // Sticky bracket error.
  typedef enum logic [1:0] {
    BRK_NONE     = 2'd0,
    BRK_MISMATCH = 2'd1,
    BRK_DEEP     = 2'd2
  } brk_err_t;

  // Reported error codes.
  typedef enum logic [3:0] {
    ERR_NONE     = 4'd0,
    ERR_BRACKET  = 4'd1,
    ERR_OPS      = 4'd2,
    ERR_LETTER   = 4'd3,
    ERR_OP_CLOSE = 4'd4,
    ERR_OPEN_OP  = 4'd5,
    ERR_NO_OP    = 4'd6,
    ERR_END      = 4'd7,
    ERR_DEEP     = 4'd8
  } err_code_t;

  // Shift commands passed along the stack cells.
  typedef struct packed {
    logic push;
    logic pop;
  } shift_ctrl_t;

  // Character codes.
  localparam char_t CH_LPAREN = 8'h28;
  localparam char_t CH_RPAREN = 8'h29;
  localparam char_t CH_LBRACE = 8'h7B;
  localparam char_t CH_RBRACE = 8'h7D;
  localparam char_t CH_LSQ    = 8'h5B;
  localparam char_t CH_RSQ    = 8'h5D;
  localparam char_t CH_PLUS   = 8'h2B;
  localparam char_t CH_MINUS  = 8'h2D;
  localparam char_t CH_STAR   = 8'h2A;
  localparam char_t CH_SLASH  = 8'h2F;
  localparam char_t CH_CARET  = 8'h5E;
  localparam char_t CH_ZERO   = 8'h30;
  localparam char_t CH_NINE   = 8'h39;
  localparam char_t CH_LO_A   = 8'h61;
  localparam char_t CH_LO_Z   = 8'h7A;
  localparam char_t CH_UP_A   = 8'h41;
  localparam char_t CH_UP_Z   = 8'h5A;

  function automatic kind_t open_kind(input char_t c);
    kind_t k;
    case (c)
      CH_LPAREN: k = KIND_PAREN;
      CH_LBRACE: k = KIND_BRACE;
      CH_LSQ:    k = KIND_SQUARE;
      default:   k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic kind_t close_kind(input char_t c);
    kind_t k;
    case (c)
      CH_RPAREN: k = KIND_PAREN;
      CH_RBRACE: k = KIND_BRACE;
      CH_RSQ:    k = KIND_SQUARE;
      default:   k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic logic is_hi_op(input char_t c);
    return c inside {CH_STAR, CH_SLASH, CH_CARET};
  endfunction

  function automatic logic is_op(input char_t c);
    return c inside {CH_STAR, CH_SLASH, CH_CARET, CH_PLUS, CH_MINUS};
  endfunction

  function automatic logic is_digit(input char_t c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  function automatic logic is_letter(input char_t c);
    return c inside {[CH_LO_A:CH_LO_Z], [CH_UP_A:CH_UP_Z]};
  endfunction

  // Classifies an adjacent pair; the tests run in priority order.
  function automatic err_code_t pair_check(input char_t a, input char_t b);
    err_code_t e;
    if (is_op(a) && is_hi_op(b)) begin
      e = ERR_OPS;
    end else if (is_letter(a) || is_letter(b)) begin
      e = ERR_LETTER;
    end else if (is_op(a) && (close_kind(b) != KIND_NONE)) begin
      e = ERR_OP_CLOSE;
    end else if ((open_kind(a) != KIND_NONE) && is_hi_op(b)) begin
      e = ERR_OPEN_OP;
    end else if ((is_digit(a) && (open_kind(b) != KIND_NONE)) ||
                 ((close_kind(a) != KIND_NONE) && is_digit(b))) begin
      e = ERR_NO_OP;
    end else begin
      e = ERR_NONE;
    end
    return e;
  endfunction

endpackage

// ----- rtl/esc_in_if.sv -----
`timescale 1ns / 1ps

// Character channel.
interface esc_in_if;
  logic           valid;
  logic           ready;
  esc_pkg::char_t ch;
  logic           last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

// ----- rtl/esc_out_if.sv -----
`timescale 1ns / 1ps

// Verdict channel.
interface esc_out_if;
  logic                valid;
  logic                ready;
  logic                valid_res;
  esc_pkg::err_code_t  error_code;
  esc_pkg::pos_t       error_index;

  modport source (output valid, output valid_res, output error_code, output error_index,
                  input ready);
  modport sink   (input valid, input valid_res, input error_code, input error_index,
                  output ready);
endinterface

// ----- rtl/esc_stack_cell.sv -----
`timescale 1ns / 1ps

// One level of the bracket stack. On a push it takes the kind from the cell
// above (nearer the top), on a pop the kind from the cell below.
module esc_stack_cell (
  input  logic                 clk,
  input  esc_pkg::shift_ctrl_t ctrl,
  input  esc_pkg::kind_t       above_kind,
  input  esc_pkg::kind_t       below_kind,
  output esc_pkg::kind_t       kind
);

  esc_pkg::kind_t kind_r;
  esc_pkg::kind_t kind_nxt;

  // Select the neighbour that moves into this level.
  always_comb begin
    kind_nxt = kind_r;
    if (ctrl.push) begin
      kind_nxt = above_kind;
    end else if (ctrl.pop) begin
      kind_nxt = below_kind;
    end
  end

  // Contents need no reset: only levels below the depth count are read.
  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
  end

  assign kind = kind_r;

endmodule

// ----- rtl/expression_syntax_checker_unit.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Payload                                  Transaction
// in_chan   input      ch[7:0], last                            valid & ready
// out_chan  output     valid_res, error_code[3:0], error_index  valid & ready
//
// One character is taken every cycle while in_chan.ready is high; the stack push or pop and the pair test
// both finish in the cycle the character is accepted.
// The verdict is registered and appears in the cycle after the final character is accepted.
// in_chan.ready drops only while a verdict waits and out_chan.ready is low.
// Reset (rst_n low, synchronous) clears the depth count and all error state.
module expression_syntax_checker_unit #(
  parameter int MAX_DEPTH = 64,
  parameter int MAX_LEN   = 4096
) (
  input  logic      clk,
  input  logic      rst_n,
  esc_in_if.sink    in_chan,
  esc_out_if.source out_chan
);

  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
  localparam int POS_LIM_I = ((MAX_LEN - 1) > 4095) ? 4095 : (MAX_LEN - 1);
  localparam esc_pkg::pos_t POS_LIM = esc_pkg::POS_W'(POS_LIM_I);
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);

  // Sequence state.
  logic [DEPTH_W-1:0]  depth_r, depth_nxt;
  esc_pkg::char_t      prev_r, prev_nxt;
  logic                have_prev_r, have_prev_nxt;
  esc_pkg::pos_t       count_r, count_nxt;
  esc_pkg::brk_err_t   brk_err_r, brk_err_nxt;
  esc_pkg::pos_t       brk_pos_r, brk_pos_nxt;
  esc_pkg::err_code_t  pair_err_r, pair_err_nxt;
  esc_pkg::pos_t       pair_pos_r, pair_pos_nxt;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  logic                res_ok_r, res_ok_nxt;
  esc_pkg::err_code_t  res_code_r, res_code_nxt;
  esc_pkg::pos_t       res_idx_r, res_idx_nxt;

  logic                accept;
  esc_pkg::kind_t      op_kind;
  esc_pkg::kind_t      cl_kind;
  esc_pkg::kind_t      top_kind;
  esc_pkg::err_code_t  pair_code;
  esc_pkg::shift_ctrl_t shift;
  esc_pkg::kind_t      kinds [MAX_DEPTH];

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign op_kind       = esc_pkg::open_kind(in_chan.ch);
  assign cl_kind       = esc_pkg::close_kind(in_chan.ch);
  assign top_kind      = kinds[0];
  assign pair_code     = esc_pkg::pair_check(prev_r, in_chan.ch);

  // Bracket stack: a row of cells, level 0 is the top.
  genvar gi;
  generate
    for (gi = 0; gi < MAX_DEPTH; gi++) begin : g_stack
      esc_pkg::kind_t above;
      esc_pkg::kind_t below;
      if (gi == 0) begin : g_top
        assign above = op_kind;
      end else begin : g_mid
        assign above = kinds[gi-1];
      end
      if (gi == MAX_DEPTH - 1) begin : g_bottom
        assign below = kinds[gi];
      end else begin : g_upper
        assign below = kinds[gi+1];
      end
      esc_stack_cell u_cell (
        .clk        (clk),
        .ctrl       (shift),
        .above_kind (above),
        .below_kind (below),
        .kind       (kinds[gi])
      );
    end
  endgenerate

  // Per-character update and verdict.
  always_comb begin
    depth_nxt     = depth_r;
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    count_nxt     = count_r;
    brk_err_nxt   = brk_err_r;
    brk_pos_nxt   = brk_pos_r;
    pair_err_nxt  = pair_err_r;
    pair_pos_nxt  = pair_pos_r;
    shift         = '0;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    res_ok_nxt    = res_ok_r;
    res_code_nxt  = res_code_r;
    res_idx_nxt   = res_idx_r;

    if (accept) begin
      // Bracket tracking stops at the first bracket error.
      if (brk_err_r == esc_pkg::BRK_NONE) begin
        if (op_kind != esc_pkg::KIND_NONE) begin
          if (depth_r >= DEPTH_MAX) begin
            brk_err_nxt = esc_pkg::BRK_DEEP;
            brk_pos_nxt = count_r;
          end else begin
            shift.push = 1'b1;
            depth_nxt  = depth_r + 1'b1;
          end
        end else if (cl_kind != esc_pkg::KIND_NONE) begin
          if ((depth_r == '0) || (top_kind != cl_kind)) begin
            brk_err_nxt = esc_pkg::BRK_MISMATCH;
            brk_pos_nxt = count_r;
          end else begin
            shift.pop = 1'b1;
            depth_nxt = depth_r - 1'b1;
          end
        end
      end

      // First bad adjacent pair is kept.
      if (have_prev_r && (pair_err_r == esc_pkg::ERR_NONE) &&
          (pair_code != esc_pkg::ERR_NONE)) begin
        pair_err_nxt = pair_code;
        pair_pos_nxt = (count_r == '0) ? '0 : count_r - 1'b1;
      end

      prev_nxt      = in_chan.ch;
      have_prev_nxt = 1'b1;
      if (count_r < POS_LIM) begin
        count_nxt = count_r + 1'b1;
      end

      if (in_chan.last) begin
        // Priority: bracket errors, unclosed bracket, pairs, bad ending.
        res_code_nxt = esc_pkg::ERR_NONE;
        res_idx_nxt  = '0;
        if (brk_err_nxt != esc_pkg::BRK_NONE) begin
          res_code_nxt = (brk_err_nxt == esc_pkg::BRK_DEEP) ? esc_pkg::ERR_DEEP
                                                            : esc_pkg::ERR_BRACKET;
          res_idx_nxt  = brk_pos_nxt;
        end else if (depth_nxt != '0) begin
          res_code_nxt = esc_pkg::ERR_BRACKET;
          res_idx_nxt  = count_r;
        end else if (pair_err_nxt != esc_pkg::ERR_NONE) begin
          res_code_nxt = pair_err_nxt;
          res_idx_nxt  = pair_pos_nxt;
        end else if (esc_pkg::is_op(in_chan.ch) || (op_kind != esc_pkg::KIND_NONE)) begin
          res_code_nxt = esc_pkg::ERR_END;
          res_idx_nxt  = count_r;
        end
        res_ok_nxt    = (res_code_nxt == esc_pkg::ERR_NONE);
        out_valid_nxt = 1'b1;

        // Everything returns to its reset value for the next expression.
        depth_nxt     = '0;
        prev_nxt      = '0;
        have_prev_nxt = 1'b0;
        count_nxt     = '0;
        brk_err_nxt   = esc_pkg::BRK_NONE;
        brk_pos_nxt   = '0;
        pair_err_nxt  = esc_pkg::ERR_NONE;
        pair_pos_nxt  = '0;
      end
    end
  end

  // Control and sequence registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= '0;
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      count_r     <= '0;
      brk_err_r   <= esc_pkg::BRK_NONE;
      brk_pos_r   <= '0;
      pair_err_r  <= esc_pkg::ERR_NONE;
      pair_pos_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      depth_r     <= depth_nxt;
      prev_r      <= prev_nxt;
      have_prev_r <= have_prev_nxt;
      count_r     <= count_nxt;
      brk_err_r   <= brk_err_nxt;
      brk_pos_r   <= brk_pos_nxt;
      pair_err_r  <= pair_err_nxt;
      pair_pos_r  <= pair_pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Verdict payload.
  always_ff @(posedge clk) begin
    res_ok_r   <= res_ok_nxt;
    res_code_r <= res_code_nxt;
    res_idx_r  <= res_idx_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.valid_res   = res_ok_r;
  assign out_chan.error_code  = res_code_r;
  assign out_chan.error_index = res_idx_r;

endmodule

// ----- rtl/esc_checker.sv -----
`timescale 1ns / 1ps
`include "expression_syntax_checker_unit_macros.svh"

// Port-level checks on the expression syntax checker.
module esc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_last,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_valid_res,
  input esc_pkg::err_code_t out_error_code,
  input esc_pkg::pos_t      out_error_index
);

  // A stalled verdict holds its value.
  `ESC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_error_code) && $stable(out_error_index),
                   "verdict changed while stalled")

  // The final character of an expression yields a verdict in the next cycle.
  `ESC_ASSERT_NEXT(a_last_gives_verdict, in_valid && in_ready && in_last, out_valid,
                   "no verdict after final character")

  // Characters are taken whenever no verdict is waiting.
  `ESC_ASSERT_SAME(a_ready_when_free, !out_valid, in_ready, "input stalled with empty output")

  // The pass flag agrees with the error code, and a pass reports index zero.
  `ESC_ASSERT_SAME(a_pass_consistent, out_valid,
                   out_valid_res == (out_error_code == esc_pkg::ERR_NONE),
                   "pass flag disagrees with code")

  `ESC_ASSERT_SAME(a_pass_index_zero, out_valid && out_valid_res, out_error_index == '0,
                   "pass with non-zero index")

endmodule

bind expression_syntax_checker_unit esc_checker u_esc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .in_last         (in_chan.last),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_valid_res   (out_chan.valid_res),
  .out_error_code  (out_chan.error_code),
  .out_error_index (out_chan.error_index)
);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int            NEST_MAX    = 64;
  localparam esc_pkg::pos_t POS_LIM     = 12'd4095;
  localparam int            RANDOM_GOAL = 400;

  // Outstanding verdict, kept in the order the expressions were closed.
  typedef struct packed {
    logic               ok;
    esc_pkg::err_code_t code;
    esc_pkg::pos_t      at;
  } verdict_t;

  // Tracks the checker's state from accepted characters and holds the verdicts still owed.
  class verdict_scoreboard;
    esc_pkg::kind_t     nest_kind [NEST_MAX];
    int unsigned        nest_depth;
    esc_pkg::char_t     prior_ch;
    bit                 prior_seen;
    esc_pkg::pos_t      ch_pos;
    esc_pkg::brk_err_t  bracket_fault;
    esc_pkg::pos_t      bracket_fault_at;
    esc_pkg::err_code_t pair_fault;
    esc_pkg::pos_t      pair_fault_at;
    verdict_t           awaited[$];
    int                 fail_count;

    function new();
      clear();
      fail_count = 0;
    endfunction

    // Everything returns to its idle value between expressions.
    function void clear();
      nest_depth       = 0;
      prior_ch         = '0;
      prior_seen       = 1'b0;
      ch_pos           = '0;
      bracket_fault    = esc_pkg::BRK_NONE;
      bracket_fault_at = '0;
      pair_fault       = esc_pkg::ERR_NONE;
      pair_fault_at    = '0;
    endfunction

    function esc_pkg::kind_t opener(esc_pkg::char_t c);
      if (c == esc_pkg::CH_LPAREN) return esc_pkg::KIND_PAREN;
      if (c == esc_pkg::CH_LBRACE) return esc_pkg::KIND_BRACE;
      if (c == esc_pkg::CH_LSQ) return esc_pkg::KIND_SQUARE;
      return esc_pkg::KIND_NONE;
    endfunction

    function esc_pkg::kind_t closer(esc_pkg::char_t c);
      if (c == esc_pkg::CH_RPAREN) return esc_pkg::KIND_PAREN;
      if (c == esc_pkg::CH_RBRACE) return esc_pkg::KIND_BRACE;
      if (c == esc_pkg::CH_RSQ) return esc_pkg::KIND_SQUARE;
      return esc_pkg::KIND_NONE;
    endfunction

    function bit is_high_prec(esc_pkg::char_t c);
      return (c == esc_pkg::CH_STAR) || (c == esc_pkg::CH_SLASH) || (c == esc_pkg::CH_CARET);
    endfunction

    function bit is_arith_op(esc_pkg::char_t c);
      return is_high_prec(c) || (c == esc_pkg::CH_PLUS) || (c == esc_pkg::CH_MINUS);
    endfunction

    function bit is_numeral(esc_pkg::char_t c);
      return (c >= esc_pkg::CH_ZERO) && (c <= esc_pkg::CH_NINE);
    endfunction

    function bit is_alpha(esc_pkg::char_t c);
      return ((c >= esc_pkg::CH_LO_A) && (c <= esc_pkg::CH_LO_Z)) ||
             ((c >= esc_pkg::CH_UP_A) && (c <= esc_pkg::CH_UP_Z));
    endfunction

    // The pair rules are tried in a fixed order; the first that fits gives the code.
    function esc_pkg::err_code_t classify_pair(esc_pkg::char_t a, esc_pkg::char_t b);
      if (is_arith_op(a) && is_high_prec(b)) return esc_pkg::ERR_OPS;
      if (is_alpha(a) || is_alpha(b)) return esc_pkg::ERR_LETTER;
      if (is_arith_op(a) && (closer(b) != esc_pkg::KIND_NONE)) return esc_pkg::ERR_OP_CLOSE;
      if ((opener(a) != esc_pkg::KIND_NONE) && is_high_prec(b)) return esc_pkg::ERR_OPEN_OP;
      if ((is_numeral(a) && (opener(b) != esc_pkg::KIND_NONE)) ||
          ((closer(a) != esc_pkg::KIND_NONE) && is_numeral(b))) return esc_pkg::ERR_NO_OP;
      return esc_pkg::ERR_NONE;
    endfunction

    // Called for every accepted input transaction.
    function void note_char(esc_pkg::char_t c, bit fin);
      esc_pkg::pos_t      here;
      esc_pkg::kind_t     ok_k;
      esc_pkg::kind_t     cl_k;
      esc_pkg::err_code_t pe;
      verdict_t           v;

      here = ch_pos;
      ok_k = opener(c);
      cl_k = closer(c);

      // Bracket tracking stops at the first bracket error.
      if (bracket_fault == esc_pkg::BRK_NONE) begin
        if (ok_k != esc_pkg::KIND_NONE) begin
          if (nest_depth >= NEST_MAX) begin
            bracket_fault    = esc_pkg::BRK_DEEP;
            bracket_fault_at = here;
          end else begin
            nest_kind[nest_depth] = ok_k;
            nest_depth++;
          end
        end else if (cl_k != esc_pkg::KIND_NONE) begin
          if ((nest_depth == 0) || (nest_kind[nest_depth-1] != cl_k)) begin
            bracket_fault    = esc_pkg::BRK_MISMATCH;
            bracket_fault_at = here;
          end else begin
            nest_depth--;
          end
        end
      end

      // Only the first bad pair is remembered.
      if (prior_seen && (pair_fault == esc_pkg::ERR_NONE)) begin
        pe = classify_pair(prior_ch, c);
        if (pe != esc_pkg::ERR_NONE) begin
          pair_fault    = pe;
          pair_fault_at = (here == 0) ? esc_pkg::pos_t'(0) : here - 1'b1;
        end
      end

      prior_ch   = c;
      prior_seen = 1'b1;
      if (ch_pos < POS_LIM) ch_pos++;

      if (!fin) return;

      v.code = esc_pkg::ERR_NONE;
      v.at   = '0;
      if (bracket_fault != esc_pkg::BRK_NONE) begin
        v.code = (bracket_fault == esc_pkg::BRK_DEEP) ? esc_pkg::ERR_DEEP : esc_pkg::ERR_BRACKET;
        v.at   = bracket_fault_at;
      end else if (nest_depth != 0) begin
        v.code = esc_pkg::ERR_BRACKET;
        v.at   = here;
      end else if (pair_fault != esc_pkg::ERR_NONE) begin
        v.code = pair_fault;
        v.at   = pair_fault_at;
      end else if (is_arith_op(c) || (ok_k != esc_pkg::KIND_NONE)) begin
        v.code = esc_pkg::ERR_END;
        v.at   = here;
      end
      v.ok = (v.code == esc_pkg::ERR_NONE);
      awaited.push_back(v);
      clear();
    endfunction

    // Called for every accepted result transaction.
    function void check_verdict(logic ok, esc_pkg::err_code_t code, esc_pkg::pos_t at);
      verdict_t v;
      if (awaited.size() == 0) begin
        $error("verdict arrived with none outstanding: valid_res %0d, error_code %0d", ok, code);
        fail_count++;
        return;
      end
      v = awaited.pop_front();
      if (ok !== v.ok) begin
        $error("valid_res mismatch: expected %0d, actual %0d", v.ok, ok);
        fail_count++;
      end
      if (code !== v.code) begin
        $error("error_code mismatch: expected %0d, actual %0d", v.code, code);
        fail_count++;
      end
      if (at !== v.at) begin
        $error("error_index mismatch: expected %0d, actual %0d", v.at, at);
        fail_count++;
      end
    endfunction

    function void check_drained();
      if (awaited.size() != 0) begin
        $error("%0d verdicts never arrived", awaited.size());
        fail_count++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  esc_in_if  in_bus ();
  esc_out_if out_bus ();

  expression_syntax_checker_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus.sink),
    .out_chan (out_bus.source)
  );

  verdict_scoreboard verdicts;
  esc_pkg::char_t expr_buf[$];
  int    chars_sent;
  int    verdicts_seen;
  int    in_run;
  int    out_run;

  esc_pkg::char_t op_set    [5] = '{esc_pkg::CH_PLUS, esc_pkg::CH_MINUS, esc_pkg::CH_STAR,
                                    esc_pkg::CH_SLASH, esc_pkg::CH_CARET};
  esc_pkg::char_t open_set  [3] = '{esc_pkg::CH_LPAREN, esc_pkg::CH_LBRACE, esc_pkg::CH_LSQ};
  esc_pkg::char_t close_set [3] = '{esc_pkg::CH_RPAREN, esc_pkg::CH_RBRACE, esc_pkg::CH_RSQ};

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the handshakes hang.
  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

  // Idle cycles before a transaction, with occasional runs of back-to-back transfers.
  function automatic int draw_gap(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      run_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 7);
  endfunction

  // A character drawn from the classes the checker distinguishes, or any byte at all.
  function automatic esc_pkg::char_t pick_char();
    case ($urandom_range(0, 5))
      0: return esc_pkg::CH_ZERO + esc_pkg::char_t'($urandom_range(0, 9));
      1: return op_set[$urandom_range(0, 4)];
      2: return open_set[$urandom_range(0, 2)];
      3: return close_set[$urandom_range(0, 2)];
      4: return $urandom_range(0, 1) ?
                esc_pkg::CH_LO_A + esc_pkg::char_t'($urandom_range(0, 25)) :
                esc_pkg::CH_UP_A + esc_pkg::char_t'($urandom_range(0, 25));
      default: return esc_pkg::char_t'($urandom_range(0, 255));
    endcase
  endfunction

  // Well-formed operand: a number, a negated number or a bracketed sub-expression.
  function automatic void put_operand(int lvl);
    int k;
    if ((lvl < 3) && ($urandom_range(0, 2) == 0)) begin
      k = $urandom_range(0, 2);
      expr_buf.push_back(open_set[k]);
      put_sum(lvl + 1);
      expr_buf.push_back(close_set[k]);
    end else begin
      if ($urandom_range(0, 5) == 0) expr_buf.push_back(esc_pkg::CH_MINUS);
      repeat ($urandom_range(1, 3))
        expr_buf.push_back(esc_pkg::CH_ZERO + esc_pkg::char_t'($urandom_range(0, 9)));
    end
  endfunction

  function automatic void put_sum(int lvl);
    put_operand(lvl);
    repeat ($urandom_range(0, 3)) begin
      expr_buf.push_back(op_set[$urandom_range(0, 4)]);
      put_operand(lvl);
    end
  endfunction

  // Well-formed expressions, some damaged by one or two edits, some pure noise.
  function automatic void build_random_expr();
    int style;
    int p;
    expr_buf.delete();
    style = $urandom_range(0, 9);
    if (style < 8) begin
      put_sum(0);
      if (style >= 5) begin
        repeat ($urandom_range(1, 2)) begin
          p = $urandom_range(0, expr_buf.size() - 1);
          case ($urandom_range(0, 3))
            0: expr_buf[p] = pick_char();
            1: expr_buf.insert(p, pick_char());
            2: if (expr_buf.size() > 1) expr_buf.delete(p);
            default: while (expr_buf.size() > p + 1) expr_buf.delete(expr_buf.size() - 1);
          endcase
        end
      end
    end else begin
      repeat ($urandom_range(1, 10)) expr_buf.push_back(pick_char());
    end
  endfunction

  // Sends the buffered expression, marking its final character as last.
  task automatic send_buffer();
    int  gap;
    bit  fin;
    for (int i = 0; i < expr_buf.size(); i++) begin
      fin = (i == expr_buf.size() - 1);
      gap = draw_gap(in_run);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_bus.valid <= 1'b1;
      in_bus.ch    <= expr_buf[i];
      in_bus.last  <= fin;
      @(posedge clk);
      while (!in_bus.ready) @(posedge clk);
      verdicts.note_char(expr_buf[i], fin);
      chars_sent++;
    end
  endtask

  task automatic send_text(input string s);
    expr_buf.delete();
    for (int i = 0; i < s.len(); i++) expr_buf.push_back(esc_pkg::char_t'(s[i]));
    send_buffer();
  endtask

  // Result side: random stalls, one long hold-off so the block backs up into its input.
  initial begin
    int gap;
    out_run = 0;
    verdicts_seen = 0;
    out_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      gap = (verdicts_seen == 20) ? 300 : draw_gap(out_run);
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk);
      while (!(out_bus.valid && rst_n)) @(posedge clk);
      verdicts.check_verdict(out_bus.valid_res, out_bus.error_code, out_bus.error_index);
      verdicts_seen++;
    end
  end

  // Stimulus and end of run.
  initial begin
    int start;
    int guard;
    verdicts   = new();
    chars_sent = 0;
    in_run     = 0;
    rst_n        <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.ch    <= '0;
    in_bus.last  <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: expressions for every error code but the depth error, lone characters and the byte extremes.
    send_text("0");
    send_text("a");
    send_text("+");
    send_text("(");
    send_text(")");
    send_text("(]");
    send_text("1+*2");
    send_text("x1");
    send_text("(2+)");
    send_text("(*2)");
    send_text("2(3)");
    send_text("(3)4");
    send_text("2+");
    send_text("{[(7-8)]^2}/9");
    expr_buf.delete();
    expr_buf.push_back(8'h00);
    send_buffer();
    expr_buf.delete();
    expr_buf.push_back(8'hFF);
    expr_buf.push_back(esc_pkg::CH_NINE);
    expr_buf.push_back(8'h00);
    send_buffer();

    // Nesting exactly at the stack limit is legal; one more level is flagged as too deep.
    expr_buf.delete();
    repeat (NEST_MAX) expr_buf.push_back(esc_pkg::CH_LPAREN);
    expr_buf.push_back(esc_pkg::CH_ZERO + 8'd1);
    repeat (NEST_MAX) expr_buf.push_back(esc_pkg::CH_RPAREN);
    send_buffer();
    expr_buf.delete();
    repeat (NEST_MAX + 1) expr_buf.push_back(esc_pkg::CH_LSQ);
    send_buffer();

    // Random expressions.
    start = chars_sent;
    while (chars_sent - start < RANDOM_GOAL) begin
      build_random_expr();
      send_buffer();
    end
    in_bus.valid <= 1'b0;

    // Drain the outstanding verdicts, then allow for the output register.
    guard = 0;
    while ((verdicts.awaited.size() != 0) && (guard < 2000)) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    verdicts.check_drained();
    if (verdicts.fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
